[rtl/core/shape_adaptive_blur_pixel_assert.svh]
// Assertion helpers for the blur block; both sample on i_clk and are off during reset.
`ifndef SHAPE_ADAPTIVE_BLUR_PIXEL_ASSERT_SVH
`define SHAPE_ADAPTIVE_BLUR_PIXEL_ASSERT_SVH

// Same-cycle implication.
`define SAB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sab: check failed");

// Next-cycle implication.
`define SAB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sab: check failed");

`endif

[rtl/core/sab_pkg.sv]
package sab_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_MAX_RADIUS = 6;

    localparam int COLOR_TABLE_SIZE = 512;
    localparam int COLOR_IDX_W      = $clog2(COLOR_TABLE_SIZE);
    localparam int COLOR_CENTER     = COLOR_TABLE_SIZE / 2;

    localparam int OPC_W     = 2;
    localparam int PIX_W     = 8;
    localparam int COORD_W   = 8;
    localparam int TIDX_W    = 9;
    localparam int WGT_W     = 13;
    localparam int SPW_W     = 11;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;
    localparam int RAD_CFG_W = 3;
    // holds any frame dimension up to 4096
    localparam int DIM_W     = 13;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_RADIUS = 2'd2;

    localparam logic [CFG_W-1:0]     RST_FRAME_WIDTH   = 9'd256;
    localparam logic [CFG_W-1:0]     RST_FRAME_HEIGHT  = 9'd256;
    localparam logic [RAD_CFG_W-1:0] RST_WINDOW_RADIUS = 3'd1;

    typedef enum logic [OPC_W-1:0] {
        OP_WRITE_PIXEL  = 2'd0,
        OP_LOAD_COLOR   = 2'd1,
        OP_LOAD_SPATIAL = 2'd2,
        OP_COMPUTE      = 2'd3
    } t_opcode;

    typedef struct packed {
        t_opcode              op;
        logic [COORD_W-1:0]   x;
        logic [COORD_W-1:0]   y;
        logic [TIDX_W-1:0]    idx;
        logic [WGT_W-1:0]     wv;
        logic [PIX_W-1:0]     src;
        logic [PIX_W-1:0]     pre;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_qhead;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CENTER,
        ST_CAPT,
        ST_WALK,
        ST_TAPS,
        ST_DRAIN,
        ST_DIV,
        ST_DONE
    } t_bstate;

endpackage

[rtl/core/shape_adaptive_blur_pixel.sv]
// Edge-preserving blur of one pixel per compute request. Load requests (pixel
// writes, color and spatial weight loads) pass through a two-deep request queue
// and are carried out by the back end straight from its idle state. In a compute
// request the window is read one tap per cycle through the single read port of
// the frame memories, and the weighted sum is then divided by the weight total
// in an 8-step restoring divider. Frame and table memories come up with
// undefined contents; nothing is cleared after reset. The result register lets
// the next request start while a finished pixel waits to be popped.
module shape_adaptive_blur_pixel #(
    parameter int MAX_WIDTH  = sab_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = sab_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = sab_pkg::DEF_MAX_RADIUS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [sab_pkg::OPC_W-1:0]     i_opcode,
    input  logic [sab_pkg::COORD_W-1:0]   i_pos_x,
    input  logic [sab_pkg::COORD_W-1:0]   i_pos_y,
    input  logic [sab_pkg::TIDX_W-1:0]    i_table_index,
    input  logic [sab_pkg::WGT_W-1:0]     i_weight_value,
    input  logic [sab_pkg::PIX_W-1:0]     i_source_pixel,
    input  logic [sab_pkg::PIX_W-1:0]     i_prefiltered_pixel,
    output logic                          empty,
    input  logic                          pop,
    output logic [sab_pkg::PIX_W-1:0]     o_filtered_pixel,
    output logic [sab_pkg::COORD_W-1:0]   o_out_x,
    output logic [sab_pkg::COORD_W-1:0]   o_out_y,
    input  logic                          i_cfg_we,
    input  logic [sab_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sab_pkg::CFG_W-1:0]     i_cfg_wdata
);

    import sab_pkg::*;

    localparam int RW = $clog2(MAX_RADIUS + 1);

    t_qhead           head;
    logic             head_pop;
    logic [DIM_W-1:0] w_dim;
    logic [DIM_W-1:0] h_dim;
    logic [RW-1:0]    radius;
    logic             result_valid;

    sab_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_push              (push),
        .o_full              (full),
        .i_opcode            (i_opcode),
        .i_pos_x             (i_pos_x),
        .i_pos_y             (i_pos_y),
        .i_table_index       (i_table_index),
        .i_weight_value      (i_weight_value),
        .i_source_pixel      (i_source_pixel),
        .i_prefiltered_pixel (i_prefiltered_pixel),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_wdata         (i_cfg_wdata),
        .o_head              (head),
        .i_head_pop          (head_pop),
        .o_w_dim             (w_dim),
        .o_h_dim             (h_dim),
        .o_radius            (radius)
    );

    sab_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (head),
        .o_head_pop       (head_pop),
        .i_w_dim          (w_dim),
        .i_h_dim          (h_dim),
        .i_radius         (radius),
        .o_result_valid   (result_valid),
        .i_result_pop     (pop),
        .o_filtered_pixel (o_filtered_pixel),
        .o_out_x          (o_out_x),
        .o_out_y          (o_out_y)
    );

    assign empty = !result_valid;

`include "shape_adaptive_blur_pixel_assert.svh"

    `SAB_ASSERT_NOW(a_pop_has_head, head_pop, head.valid)
    `SAB_ASSERT_NEXT(a_head_kept, head.valid && !head_pop, head.valid)
    `SAB_ASSERT_NEXT(a_full_kept, full && !head_pop, full)

endmodule

[rtl/core/sab_ram.sv]
module sab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[rtl/core/sab_front.sv]
module sab_front #(
    parameter int MAX_WIDTH  = sab_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = sab_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = sab_pkg::DEF_MAX_RADIUS,
    localparam int RW        = $clog2(MAX_RADIUS + 1)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    output logic                            o_full,
    input  logic [sab_pkg::OPC_W-1:0]       i_opcode,
    input  logic [sab_pkg::COORD_W-1:0]     i_pos_x,
    input  logic [sab_pkg::COORD_W-1:0]     i_pos_y,
    input  logic [sab_pkg::TIDX_W-1:0]      i_table_index,
    input  logic [sab_pkg::WGT_W-1:0]       i_weight_value,
    input  logic [sab_pkg::PIX_W-1:0]       i_source_pixel,
    input  logic [sab_pkg::PIX_W-1:0]       i_prefiltered_pixel,
    input  logic                            i_cfg_we,
    input  logic [sab_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sab_pkg::CFG_W-1:0]       i_cfg_wdata,
    output sab_pkg::t_qhead                 o_head,
    input  logic                            i_head_pop,
    output logic [sab_pkg::DIM_W-1:0]       o_w_dim,
    output logic [sab_pkg::DIM_W-1:0]       o_h_dim,
    output logic [RW-1:0]                   o_radius
);

    import sab_pkg::*;

    localparam int NSP = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);

    logic [CFG_W-1:0]     r_frame_width;
    logic [CFG_W-1:0]     r_frame_height;
    logic [RAD_CFG_W-1:0] r_window_radius;

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    t_cmd       in_cmd;
    logic       keep;
    logic       enq;
    logic [DIM_W-1:0] wd;
    logic [DIM_W-1:0] hd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width   <= RST_FRAME_WIDTH;
            r_frame_height  <= RST_FRAME_HEIGHT;
            r_window_radius <= RST_WINDOW_RADIUS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH:   r_frame_width   <= i_cfg_wdata;
                REG_FRAME_HEIGHT:  r_frame_height  <= i_cfg_wdata;
                REG_WINDOW_RADIUS: r_window_radius <= i_cfg_wdata[RAD_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // saturate geometry to what the storage supports; a zero width or height reads as one
    always_comb begin
        wd = DIM_W'(r_frame_width);
        hd = DIM_W'(r_frame_height);
        if (wd == '0) begin
            o_w_dim = DIM_W'(1);
        end else if (wd > DIM_W'(MAX_WIDTH)) begin
            o_w_dim = DIM_W'(MAX_WIDTH);
        end else begin
            o_w_dim = wd;
        end
        if (hd == '0) begin
            o_h_dim = DIM_W'(1);
        end else if (hd > DIM_W'(MAX_HEIGHT)) begin
            o_h_dim = DIM_W'(MAX_HEIGHT);
        end else begin
            o_h_dim = hd;
        end
        if (32'(r_window_radius) > MAX_RADIUS) begin
            o_radius = RW'(MAX_RADIUS);
        end else begin
            o_radius = RW'(r_window_radius);
        end
    end

    // writes that miss storage are dropped here
    always_comb begin
        in_cmd.op  = t_opcode'(i_opcode);
        in_cmd.x   = i_pos_x;
        in_cmd.y   = i_pos_y;
        in_cmd.idx = i_table_index;
        in_cmd.wv  = i_weight_value;
        in_cmd.src = i_source_pixel;
        in_cmd.pre = i_prefiltered_pixel;
        unique case (in_cmd.op)
            OP_WRITE_PIXEL:  keep = (DIM_W'(i_pos_x) < DIM_W'(MAX_WIDTH)) &&
                                    (DIM_W'(i_pos_y) < DIM_W'(MAX_HEIGHT));
            OP_LOAD_SPATIAL: keep = 32'(i_table_index) < NSP;
            default:         keep = 1'b1;
        endcase
    end

    assign o_full = (r_cnt == 2'd2);
    assign enq    = i_push && !o_full && keep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (enq) begin
                r_wp <= ~r_wp;
            end
            if (i_head_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(enq) - 2'(i_head_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_q[r_wp] <= in_cmd;
        end
    end

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.cmd   = r_q[r_rp];

endmodule

[rtl/core/sab_back.sv]
module sab_back #(
    parameter int MAX_WIDTH  = sab_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = sab_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = sab_pkg::DEF_MAX_RADIUS,
    localparam int RW        = $clog2(MAX_RADIUS + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sab_pkg::t_qhead               i_head,
    output logic                          o_head_pop,
    input  logic [sab_pkg::DIM_W-1:0]     i_w_dim,
    input  logic [sab_pkg::DIM_W-1:0]     i_h_dim,
    input  logic [RW-1:0]                 i_radius,
    output logic                          o_result_valid,
    input  logic                          i_result_pop,
    output logic [sab_pkg::PIX_W-1:0]     o_filtered_pixel,
    output logic [sab_pkg::COORD_W-1:0]   o_out_x,
    output logic [sab_pkg::COORD_W-1:0]   o_out_y
);

    import sab_pkg::*;

    localparam int XW     = $clog2(MAX_WIDTH);
    localparam int YW     = $clog2(MAX_HEIGHT);
    localparam int AW     = XW + YW;
    localparam int FDEPTH = 1 << AW;
    localparam int PW     = (XW > YW) ? XW : YW;
    localparam int SPW    = $clog2(2 * MAX_RADIUS + 2);
    localparam int NSP    = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
    localparam int SIW    = $clog2(NSP);
    localparam int NTW    = $clog2(NSP + 1);
    localparam int FW     = WGT_W + SPW_W;
    localparam int SW     = FW + PIX_W + NTW;
    localparam int QW     = PIX_W;

    t_bstate r_state, n_state;

    logic [XW-1:0]    r_cx, r_tx, r_x0;
    logic [YW-1:0]    r_cy, r_ty;
    logic             r_txd, r_tyd, r_x0d;
    logic [COORD_W-1:0] r_ox, r_oy;
    logic [PIX_W-1:0] r_cpre, r_csrc;
    logic [RW-1:0]    r_k;
    logic [SPW-1:0]   r_dx, r_dy;
    logic [SIW-1:0]   r_sidx;
    logic             r_v1, r_v2, r_v3;
    logic [PIX_W-1:0] r_src1, r_src2;
    logic [SPW_W-1:0] r_sw1;
    logic [FW-1:0]    r_f;
    logic [SW-1:0]    r_sum, r_total, r_rem, r_dvs;
    logic [QW-1:0]    r_q;
    logic [2:0]       r_dcnt;
    logic             r_ov;
    logic [PIX_W-1:0] r_res;
    logic [COORD_W-1:0] r_resx, r_resy;

    logic [XW-1:0]    w_last, cx_n;
    logic [YW-1:0]    h_last, cy_n;
    logic [SPW-1:0]   span_last;
    logic [PW:0]      xs, ys;
    logic [AW-1:0]    f_raddr, f_waddr;
    logic             f_we, c_we, s_we;
    logic [PIX_W-1:0] src_rd, pre_rd;
    logic [WGT_W-1:0] cw_rd;
    logic [SPW_W-1:0] sw_rd;
    logic [COLOR_IDX_W-1:0] cidx;
    logic [FW-1:0]    f_prod;
    logic [PIX_W+FW-1:0] s_prod;
    logic             ge;

    // one step of a mirrored walk; d high means moving up
    function automatic logic [PW:0] walk_step(input logic [PW-1:0] p, input logic d,
                                              input logic [PW-1:0] top);
        logic [PW:0] res;
        if (top == '0) begin
            res = {d, {PW{1'b0}}};
        end else if (d) begin
            res = (p == top) ? {1'b0, top - 1'b1} : {1'b1, p + 1'b1};
        end else begin
            res = (p == '0) ? {1'b1, PW'(1)} : {1'b0, p - 1'b1};
        end
        return res;
    endfunction

    assign w_last    = XW'(i_w_dim - 1'b1);
    assign h_last    = YW'(i_h_dim - 1'b1);
    assign cx_n      = (DIM_W'(i_head.cmd.x) < i_w_dim) ? XW'(i_head.cmd.x) : w_last;
    assign cy_n      = (DIM_W'(i_head.cmd.y) < i_h_dim) ? YW'(i_head.cmd.y) : h_last;
    assign span_last = SPW'({i_radius, 1'b0});
    assign xs        = walk_step(PW'(r_tx), r_txd, PW'(w_last));
    assign ys        = walk_step(PW'(r_ty), r_tyd, PW'(h_last));

    assign f_raddr = (r_state == ST_CENTER) ? {r_cy, r_cx} : {r_ty, r_tx};
    assign f_waddr = {YW'(i_head.cmd.y), XW'(i_head.cmd.x)};
    assign f_we    = o_head_pop && (i_head.cmd.op == OP_WRITE_PIXEL);
    assign c_we    = o_head_pop && (i_head.cmd.op == OP_LOAD_COLOR);
    assign s_we    = o_head_pop && (i_head.cmd.op == OP_LOAD_SPATIAL);
    assign cidx    = COLOR_IDX_W'(COLOR_CENTER) + COLOR_IDX_W'(r_cpre)
                   - COLOR_IDX_W'(pre_rd);
    assign f_prod  = FW'(cw_rd) * FW'(r_sw1);
    assign s_prod  = (PIX_W+FW)'(r_src2) * (PIX_W+FW)'(r_f);
    assign ge      = (r_rem >= r_dvs);

    sab_ram #(.WIDTH(PIX_W), .DEPTH(FDEPTH)) u_src_ram (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (f_waddr),
        .i_wdata (i_head.cmd.src),
        .i_raddr (f_raddr),
        .o_rdata (src_rd)
    );

    sab_ram #(.WIDTH(PIX_W), .DEPTH(FDEPTH)) u_pre_ram (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (f_waddr),
        .i_wdata (i_head.cmd.pre),
        .i_raddr (f_raddr),
        .o_rdata (pre_rd)
    );

    sab_ram #(.WIDTH(WGT_W), .DEPTH(COLOR_TABLE_SIZE)) u_color_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (COLOR_IDX_W'(i_head.cmd.idx)),
        .i_wdata (i_head.cmd.wv),
        .i_raddr (cidx),
        .o_rdata (cw_rd)
    );

    sab_ram #(.WIDTH(SPW_W), .DEPTH(NSP)) u_spatial_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (SIW'(i_head.cmd.idx)),
        .i_wdata (i_head.cmd.wv[SPW_W-1:0]),
        .i_raddr (r_sidx),
        .o_rdata (sw_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_head_pop = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_head.valid) begin
                    o_head_pop = 1'b1;
                    if (i_head.cmd.op == OP_COMPUTE) begin
                        n_state = ST_CENTER;
                    end
                end
            end
            ST_CENTER: n_state = ST_CAPT;
            ST_CAPT:   n_state = ST_WALK;
            ST_WALK: begin
                if (r_k == '0) begin
                    n_state = ST_TAPS;
                end
            end
            ST_TAPS: begin
                if (r_dx == span_last && r_dy == span_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_v1 && !r_v2 && !r_v3) begin
                    n_state = (r_total == '0) ? ST_DONE : ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_dcnt == 3'd7) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_ov || i_result_pop) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_v1 <= (r_state == ST_TAPS);
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (r_state == ST_DONE && n_state == ST_IDLE) begin
                r_ov <= 1'b1;
            end else if (i_result_pop) begin
                r_ov <= 1'b0;
            end
        end
    end

    // tap pipeline: frame read, color read, weight product, accumulate
    always_ff @(posedge i_clk) begin
        r_src1 <= src_rd;
        r_sw1  <= sw_rd;
        r_src2 <= r_src1;
        r_f    <= f_prod;

        case (r_state)
            ST_IDLE: begin
                r_cx <= cx_n;
                r_cy <= cy_n;
                r_ox <= i_head.cmd.x;
                r_oy <= i_head.cmd.y;
            end
            ST_CAPT: begin
                r_cpre <= pre_rd;
                r_csrc <= src_rd;
                r_k    <= i_radius;
                r_tx   <= r_cx;
                r_txd  <= 1'b0;
                r_ty   <= r_cy;
                r_tyd  <= 1'b0;
            end
            ST_WALK: begin
                if (r_k == '0) begin
                    // walked back r steps; turn around for the forward scan
                    r_x0    <= r_tx;
                    r_x0d   <= ~r_txd;
                    r_txd   <= ~r_txd;
                    r_tyd   <= ~r_tyd;
                    r_dx    <= '0;
                    r_dy    <= '0;
                    r_sidx  <= '0;
                    r_sum   <= '0;
                    r_total <= '0;
                end else begin
                    r_tx  <= XW'(xs[PW-1:0]);
                    r_txd <= xs[PW];
                    r_ty  <= YW'(ys[PW-1:0]);
                    r_tyd <= ys[PW];
                    r_k   <= r_k - 1'b1;
                end
            end
            ST_TAPS: begin
                r_sidx <= r_sidx + 1'b1;
                if (r_dx == span_last) begin
                    r_dx  <= '0;
                    r_dy  <= r_dy + 1'b1;
                    r_tx  <= r_x0;
                    r_txd <= r_x0d;
                    r_ty  <= YW'(ys[PW-1:0]);
                    r_tyd <= ys[PW];
                end else begin
                    r_dx  <= r_dx + 1'b1;
                    r_tx  <= XW'(xs[PW-1:0]);
                    r_txd <= xs[PW];
                end
            end
            ST_DRAIN: begin
                // rounding bias added up front; quotient always fits eight bits
                r_rem  <= r_sum + (r_total >> 1);
                r_dvs  <= r_total << (QW - 1);
                r_dcnt <= '0;
            end
            ST_DIV: begin
                if (ge) begin
                    r_rem <= r_rem - r_dvs;
                end
                r_q    <= {r_q[QW-2:0], ge};
                r_dvs  <= r_dvs >> 1;
                r_dcnt <= r_dcnt + 1'b1;
            end
            ST_DONE: begin
                if (n_state == ST_IDLE) begin
                    r_res  <= (r_total == '0) ? r_csrc : r_q;
                    r_resx <= r_ox;
                    r_resy <= r_oy;
                end
            end
            default: ;
        endcase

        if (r_v3) begin
            r_sum   <= r_sum + SW'(s_prod);
            r_total <= r_total + SW'(r_f);
        end
    end

    assign o_result_valid   = r_ov;
    assign o_filtered_pixel = r_res;
    assign o_out_x          = r_resx;
    assign o_out_y          = r_resy;

endmodule
